[hw/rtl/framed_packet_parser_with_ack_defines.svh]
// Assertion macros for the framed packet parser top level.
`ifndef FRAMED_PACKET_PARSER_WITH_ACK_DEFINES_SVH
`define FRAMED_PACKET_PARSER_WITH_ACK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FPP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fpp check failed");

// Next-cycle implication, disabled during reset.
`define FPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fpp check failed");

`endif

[hw/rtl/fpp_pkg.sv]
// Package with phase codes, register indexes and acknowledge constants.
package fpp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned BEAT_W = 3;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [PHASE_W-1:0]   t_phase;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [BEAT_W-1:0]    t_beat;

    localparam t_phase PH_HUNT = 3'd0;
    localparam t_phase PH_CMD  = 3'd1;
    localparam t_phase PH_LEN  = 3'd2;
    localparam t_phase PH_DATA = 3'd3;
    localparam t_phase PH_STOP = 3'd4;

    localparam t_cfg_idx CFG_START = 2'd0;
    localparam t_cfg_idx CFG_STOP  = 2'd1;
    localparam t_cfg_idx CFG_ACK   = 2'd2;

    localparam t_byte START_RST = 8'h55;
    localparam t_byte STOP_RST  = 8'hAA;
    localparam t_byte ACK_RST   = 8'hFF;
    localparam t_byte ACK_LEN   = 8'h00;

    // Beats of one output run: echo, then the acknowledge frame.
    localparam t_beat BEAT_ECHO  = 3'd0;
    localparam t_beat BEAT_START = 3'd1;
    localparam t_beat BEAT_CMD   = 3'd2;
    localparam t_beat BEAT_LEN   = 3'd3;
    localparam t_beat BEAT_STOP  = 3'd4;

endpackage

[hw/rtl/framed_packet_parser_with_ack.sv]
// Top level: framed packet parser that echoes each byte and acknowledges good frames.
//
//  channel   dir  tdata (low bit up)   tlast         notes
//  s_axis    in   rx_byte[7:0]         -             one received byte per item
//  m_axis    out  tx_byte[7:0]         last_of_run   echo, then 4 ack bytes if any
//  cfg       in   i_cfg_wdata[7:0]     -             0 start, 1 stop, 2 ack command
//
// Items pass from the input register to a free output run register. With m_axis
// ready, echo-only items flow at one per cycle; an acknowledged frame holds the
// output run register for five beats; the next item waits in the input register.
// Reset (synchronous, active low) empties both registers, sets hunting, and loads
// the register defaults. A stalled m_axis holds the run and back-pressures s_axis.
`include "framed_packet_parser_with_ack_defines.svh"

module framed_packet_parser_with_ack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  fpp_pkg::t_byte      s_axis_tdata,   // [7:0] rx_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output fpp_pkg::t_byte      m_axis_tdata,   // [7:0] tx_byte
    output logic                m_axis_tlast,   // last_of_run
    input  logic                i_cfg_we,
    input  fpp_pkg::t_cfg_idx   i_cfg_idx,
    input  fpp_pkg::t_byte      i_cfg_wdata
);
    import fpp_pkg::*;

    t_byte r_start, r_stop, r_ackcmd;

    logic  r_in_vld;
    t_byte r_in_byte;

    logic  r_out_vld;
    t_byte r_out_echo;
    logic  r_out_ack;
    t_beat r_out_beat;

    logic  w_ack, w_in_take, w_out_fire, w_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= START_RST;
            r_stop   <= STOP_RST;
            r_ackcmd <= ACK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START: r_start  <= i_cfg_wdata;
                CFG_STOP:  r_stop   <= i_cfg_wdata;
                CFG_ACK:   r_ackcmd <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign w_out_fire    = r_out_vld && m_axis_tready;
    assign w_out_done    = w_out_fire && m_axis_tlast;
    assign w_in_take     = r_in_vld && (!r_out_vld || w_out_done);
    assign s_axis_tready = !r_in_vld || w_in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_in_byte <= s_axis_tdata;
    end

    fpp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_in_take),
        .i_byte         (r_in_byte),
        .i_start_marker (r_start),
        .i_stop_marker  (r_stop),
        .o_ack          (w_ack)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_out_beat <= BEAT_ECHO;
        end else if (w_in_take) begin
            r_out_vld  <= 1'b1;
            r_out_beat <= BEAT_ECHO;
        end else if (w_out_done) begin
            r_out_vld  <= 1'b0;
            r_out_beat <= BEAT_ECHO;
        end else if (w_out_fire) begin
            r_out_beat <= r_out_beat + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_out_echo <= r_in_byte;
            r_out_ack  <= w_ack;
        end
    end

    always_comb begin
        unique case (r_out_beat)
            BEAT_ECHO:  m_axis_tdata = r_out_echo;
            BEAT_START: m_axis_tdata = r_start;
            BEAT_CMD:   m_axis_tdata = r_ackcmd;
            BEAT_LEN:   m_axis_tdata = ACK_LEN;
            BEAT_STOP:  m_axis_tdata = r_stop;
            default:    m_axis_tdata = r_out_echo;
        endcase
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = !r_out_ack || (r_out_beat == BEAT_STOP);

    // beat counter stays inside the acknowledge frame
    `FPP_ASSERT_NOW(a_beat_range, i_clk, i_rst_n, r_out_vld, r_out_beat <= BEAT_STOP)
    // an echo-only run never advances past its first beat
    `FPP_ASSERT_NOW(a_echo_single, i_clk, i_rst_n, r_out_vld && !r_out_ack,
                    r_out_beat == BEAT_ECHO)
    // a finished run with nothing queued leaves the output empty
    `FPP_ASSERT_NEXT(a_drain, i_clk, i_rst_n, w_out_done && !r_in_vld, !m_axis_tvalid)
    // a new item always starts its run at the echo beat
    `FPP_ASSERT_NEXT(a_run_start, i_clk, i_rst_n, w_in_take,
                     m_axis_tvalid && (r_out_beat == BEAT_ECHO))

endmodule

[hw/rtl/fpp_parser.sv]
// Frame phase tracker: decides per byte whether an acknowledge follows.
module fpp_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  fpp_pkg::t_byte i_byte,
    input  fpp_pkg::t_byte i_start_marker,
    input  fpp_pkg::t_byte i_stop_marker,
    output logic          o_ack
);
    import fpp_pkg::*;

    t_phase r_phase, n_phase;
    t_byte  r_remain, n_remain;
    t_byte  w_dec;

    assign w_dec = r_remain - 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_remain = r_remain;
        o_ack    = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_start_marker) n_phase = PH_CMD;
            end
            PH_CMD: begin
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_remain = i_byte;
                n_phase  = (i_byte == 8'd0) ? PH_STOP : PH_DATA;
            end
            PH_DATA: begin
                n_remain = w_dec;
                if (w_dec == 8'd0) n_phase = PH_STOP;
            end
            PH_STOP: begin
                o_ack   = (i_byte == i_stop_marker);
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_remain <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
        end
    end

endmodule

[tb/framed_packet_parser_with_ack_tb.sv]
// Testbench for the framed packet parser: directed table, then random frames per marker set.
module framed_packet_parser_with_ack_tb;
    import fpp_pkg::*;

    localparam t_cfg_idx CFG_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int N_DIRECTED = 26;
    localparam int N_SETTINGS = 6;

    typedef enum logic [1:0] {EXP_PREDICT, EXP_ECHO, EXP_ACK_DEFAULT} t_exp_src;

    typedef struct packed {
        t_byte    rx;
        t_exp_src src;
    } t_stim_row;

    typedef struct packed {
        t_byte tx;
        logic  last;
    } t_tx_item;

    typedef struct packed {
        t_byte start_mk;
        t_byte stop_mk;
        t_byte ack_cmd;
    } t_marker_set;

    // Runs right after reset, so the acknowledge bytes are the register defaults.
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00, EXP_ECHO},         // hunting, no start
        '{8'hFF, EXP_ECHO},
        '{8'h55, EXP_ECHO},         // start
        '{8'h55, EXP_ECHO},         // start marker taken as command
        '{8'h00, EXP_ECHO},         // zero length skips data
        '{8'hAA, EXP_ACK_DEFAULT},
        '{8'h55, EXP_ECHO},
        '{8'h01, EXP_ECHO},
        '{8'h02, EXP_ECHO},
        '{8'h55, EXP_PREDICT},      // start marker as data
        '{8'hAA, EXP_PREDICT},      // stop marker as data
        '{8'hAA, EXP_ACK_DEFAULT},
        '{8'h55, EXP_ECHO},
        '{8'h7F, EXP_ECHO},
        '{8'h00, EXP_ECHO},
        '{8'h54, EXP_ECHO},         // wrong stop byte
        '{8'hAA, EXP_ECHO},         // stop marker while hunting
        '{8'h55, EXP_ECHO},
        '{8'h80, EXP_ECHO},
        '{8'h01, EXP_ECHO},
        '{8'hFF, EXP_PREDICT},
        '{8'hAA, EXP_ACK_DEFAULT},
        '{8'h55, EXP_ECHO},
        '{8'h00, EXP_ECHO},
        '{8'h00, EXP_ECHO},
        '{8'h55, EXP_ECHO}          // start marker in stop position
    };

    logic     i_clk;
    logic     i_rst_n;
    logic     s_axis_tvalid;
    logic     s_axis_tready;
    t_byte    s_axis_tdata;
    logic     m_axis_tvalid;
    logic     m_axis_tready;
    t_byte    m_axis_tdata;
    logic     m_axis_tlast;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_byte    i_cfg_wdata;

    // Predictor state
    t_byte  start_mk;
    t_byte  stop_mk;
    t_byte  ack_cmd;
    t_phase frame_phase;
    t_byte  data_left;

    t_tx_item tx_expect_q[$];
    bit       steady;
    int       fail_cnt;
    int       rx_cnt;
    int       tx_cnt;
    int       ack_cnt;
    int       settings_cnt;

    framed_packet_parser_with_ack dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 500_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly short gaps, a few long ones; none during a steady stretch.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady) return 0;
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Advances the frame tracker by one byte; returns 1 when the frame is acknowledged.
    function automatic bit advance_frame(input t_byte b);
        bit ack;
        ack = 1'b0;
        case (frame_phase)
            PH_HUNT: begin
                if (b == start_mk) frame_phase = PH_CMD;
            end
            PH_CMD: begin
                frame_phase = PH_LEN;
            end
            PH_LEN: begin
                data_left = b;
                frame_phase = (b == 8'd0) ? PH_STOP : PH_DATA;
            end
            PH_DATA: begin
                data_left = data_left - 8'd1;
                if (data_left == 8'd0) frame_phase = PH_STOP;
            end
            PH_STOP: begin
                ack = (b == stop_mk);
                frame_phase = PH_HUNT;
            end
            default: begin
                frame_phase = PH_HUNT;
            end
        endcase
        return ack;
    endfunction

    task automatic queue_run(input t_byte b, input bit ack, input t_byte s_mk,
                             input t_byte cmd, input t_byte e_mk);
        tx_expect_q.push_back('{b, ~ack});
        if (ack) begin
            tx_expect_q.push_back('{s_mk, 1'b0});
            tx_expect_q.push_back('{cmd, 1'b0});
            tx_expect_q.push_back('{ACK_LEN, 1'b0});
            tx_expect_q.push_back('{e_mk, 1'b1});
            ack_cnt++;
        end
    endtask

    task automatic send_rx(input t_byte b, input t_exp_src src);
        int gap;
        bit ack;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rx_cnt++;
        ack = advance_frame(b);
        case (src)
            EXP_ECHO:        queue_run(b, 1'b0, start_mk, ack_cmd, stop_mk);
            EXP_ACK_DEFAULT: queue_run(b, 1'b1, START_RST, ACK_RST, STOP_RST);
            default:         queue_run(b, ack, start_mk, ack_cmd, stop_mk);
        endcase
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_byte val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_START: start_mk = val;
            CFG_STOP:  stop_mk = val;
            CFG_ACK:   ack_cmd = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tx_expect_q.size() != 0) @(posedge i_clk);
        // input and output registers, plus margin
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random content; some bad stops and loose noise.
    task automatic send_burst();
        int r;
        int n;
        t_byte bad;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            n = $urandom_range(1, 4);
            repeat (n) send_rx(t_byte'($urandom), EXP_PREDICT);
            return;
        end
        n = $urandom_range(0, 99);
        n = (n < 15) ? 0 : (n < 88) ? $urandom_range(1, 4) : $urandom_range(5, 24);
        send_rx(start_mk, EXP_PREDICT);
        send_rx(t_byte'($urandom), EXP_PREDICT);
        send_rx(t_byte'(n), EXP_PREDICT);
        repeat (n) send_rx(t_byte'($urandom), EXP_PREDICT);
        if (r < 85) begin
            send_rx(stop_mk, EXP_PREDICT);
        end else begin
            bad = t_byte'($urandom);
            while (bad == stop_mk) bad = t_byte'($urandom);
            send_rx(bad, EXP_PREDICT);
        end
    endtask

    // Output side: check accepted items, then pick ready for the next cycle.
    initial begin
        int stall_left;
        t_tx_item exp_item;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                tx_cnt++;
                if (tx_expect_q.size() == 0) begin
                    $error("tx item 0x%02h arrived with nothing expected", m_axis_tdata);
                    fail_cnt++;
                end else begin
                    exp_item = tx_expect_q.pop_front();
                    if (m_axis_tdata !== exp_item.tx) begin
                        $error("tx_byte: expected 0x%02h, got 0x%02h",
                               exp_item.tx, m_axis_tdata);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== exp_item.last) begin
                        $error("last_of_run: expected %0b, got %0b",
                               exp_item.last, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = idle_len();
                if (stall_left > 0) begin
                    m_axis_tready <= 1'b0;
                    stall_left--;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        t_marker_set settings [N_SETTINGS];
        int base;
        settings[0] = '{START_RST, STOP_RST, ACK_RST};
        settings[1] = '{8'h00, 8'hFF, 8'h00};
        settings[2] = '{8'hFF, 8'h00, 8'h80};
        settings[3] = '{8'h3C, 8'h3C, 8'h5A};    // start and stop share a value
        settings[4] = '{t_byte'($urandom), t_byte'($urandom), t_byte'($urandom)};
        settings[5] = '{t_byte'($urandom), t_byte'($urandom), t_byte'($urandom)};

        fail_cnt = 0;
        rx_cnt = 0;
        tx_cnt = 0;
        ack_cnt = 0;
        settings_cnt = 1;
        steady = 1'b0;
        start_mk = START_RST;
        stop_mk = STOP_RST;
        ack_cmd = ACK_RST;
        frame_phase = PH_HUNT;
        data_left = 8'd0;

        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'h00;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_START;
        i_cfg_wdata <= 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_rx(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].src);
        end

        for (int p = 0; p < N_SETTINGS; p++) begin
            if (p > 0) begin
                drain();
                write_reg(CFG_START, settings[p].start_mk);
                write_reg(CFG_STOP, settings[p].stop_mk);
                write_reg(CFG_ACK, settings[p].ack_cmd);
                // unused index must leave every register alone
                if (p == 2) write_reg(CFG_UNUSED, t_byte'($urandom));
                i_cfg_we <= 1'b0;
                settings_cnt++;
            end
            base = rx_cnt;
            while (rx_cnt - base < ITEMS_PER_PHASE) begin
                steady = ($urandom_range(0, 4) == 0);
                send_burst();
            end
            steady = 1'b0;
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d rx items under %0d marker settings; checked %0d tx items,",
                 rx_cnt, settings_cnt, tx_cnt);
        $display("including %0d acknowledge runs, with random gaps and stalls on both sides.",
                 ack_cnt);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fpp_pkg.sv
hw/rtl/fpp_parser.sv
hw/rtl/framed_packet_parser_with_ack.sv
tb/framed_packet_parser_with_ack_tb.sv
